>>> design/bcf_pkg.sv
// Shared types, codes and constants of the box containment filter.
`default_nettype none

package bcf_pkg;

	localparam int COORD_W    = 16;
	localparam int AREA_W     = 32;
	localparam int ASPECT_W   = 8;
	localparam int ASP_PROD_W = COORD_W + ASPECT_W;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int KIND_W     = 2;
	localparam int CNT_OUT_W  = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_OFFER  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_SMALL     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ASPECT    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_CONTAINED = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_ENTRY     = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd6;

	localparam logic [KIND_W-1:0] KIND_OFFER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ASPECT = 8'd1;

	localparam logic [COORD_W-1:0]  MIN_AREA_RST   = 16'd25;
	localparam logic [ASPECT_W-1:0] MAX_ASPECT_RST = 8'd25;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [COORD_W-1:0] height;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} box_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
		box_t                box;
		logic [AREA_W-1:0]   area;
	} job_t;

endpackage

`default_nettype wire

>>> design/bcf_ifs.sv
// Request, result and configuration channel interfaces of the box containment filter.
`default_nettype none

interface bcf_req_if;
	logic                          valid;
	logic                          ready;
	logic [bcf_pkg::CMD_W-1:0]     command;
	logic [bcf_pkg::COORD_W-1:0]   box_x;
	logic [bcf_pkg::COORD_W-1:0]   box_y;
	logic [bcf_pkg::COORD_W-1:0]   box_width;
	logic [bcf_pkg::COORD_W-1:0]   box_height;

	modport source(output valid, command, box_x, box_y, box_width, box_height, input ready);
	modport sink(input valid, command, box_x, box_y, box_width, box_height, output ready);
endinterface

interface bcf_res_if;
	logic                          valid;
	logic                          ready;
	logic [bcf_pkg::STATUS_W-1:0]  status;
	logic [bcf_pkg::CNT_OUT_W-1:0] removed_count;
	logic [bcf_pkg::CNT_OUT_W-1:0] stored_count;
	logic [bcf_pkg::COORD_W-1:0]   entry_x;
	logic [bcf_pkg::COORD_W-1:0]   entry_y;
	logic [bcf_pkg::COORD_W-1:0]   entry_width;
	logic [bcf_pkg::COORD_W-1:0]   entry_height;
	logic                          entry_valid;
	logic                          last;

	modport source(output valid, status, removed_count, stored_count, entry_x, entry_y,
		entry_width, entry_height, entry_valid, last, input ready);
	modport sink(input valid, status, removed_count, stored_count, entry_x, entry_y,
		entry_width, entry_height, entry_valid, last, output ready);
endinterface

interface bcf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bcf_pkg::CFG_IDX_W-1:0]  index;
	logic [bcf_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/bcf_front.sv
// Front end: takes requests and registers, computes area and aspect, classifies each request.
`default_nettype none

module bcf_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bcf_req_if.sink      req,
	bcf_cfg_if.sink      cfg,
	output bcf_pkg::job_t job,
	output logic         job_valid,
	input  wire logic    job_ready
);

	logic [bcf_pkg::COORD_W-1:0]    min_area_q;
	logic [bcf_pkg::ASPECT_W-1:0]   max_aspect_q;

	logic                           v_s1;
	logic [bcf_pkg::CMD_W-1:0]      cmd_s1;
	bcf_pkg::box_t                  box_s1;

	logic                           v_s2;
	logic [bcf_pkg::CMD_W-1:0]      cmd_s2;
	bcf_pkg::box_t                  box_s2;
	logic [bcf_pkg::AREA_W-1:0]     area_s2;
	logic [bcf_pkg::ASP_PROD_W-1:0] asp_h_s2;
	logic [bcf_pkg::ASP_PROD_W-1:0] asp_w_s2;

	logic [bcf_pkg::AREA_W-1:0]     area_d;
	logic [bcf_pkg::ASP_PROD_W-1:0] asp_h_d;
	logic [bcf_pkg::ASP_PROD_W-1:0] asp_w_d;
	logic                           s2_take;
	logic                           s2_free;
	logic                           s1_move;
	logic                           bad_aspect;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q   <= bcf_pkg::MIN_AREA_RST;
			max_aspect_q <= bcf_pkg::MAX_ASPECT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bcf_pkg::REG_MIN_AREA:   min_area_q   <= cfg.data[bcf_pkg::COORD_W-1:0];
				bcf_pkg::REG_MAX_ASPECT: max_aspect_q <= cfg.data[bcf_pkg::ASPECT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s2_take   = v_s2 && (job_ready || (cmd_s2 == bcf_pkg::CMD_UNUSED));
	assign s2_free   = !v_s2 || s2_take;
	assign s1_move   = v_s1 && s2_free;
	assign req.ready = !v_s1 || s2_free;
	assign job_valid = v_s2 && (cmd_s2 != bcf_pkg::CMD_UNUSED);

	assign area_d  = bcf_pkg::AREA_W'(box_s1.width) * bcf_pkg::AREA_W'(box_s1.height);
	assign asp_h_d = bcf_pkg::ASP_PROD_W'(max_aspect_q) * bcf_pkg::ASP_PROD_W'(box_s1.height);
	assign asp_w_d = bcf_pkg::ASP_PROD_W'(max_aspect_q) * bcf_pkg::ASP_PROD_W'(box_s1.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_s2 <= 1'b1;
			end else if (s2_take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1        <= req.command;
			box_s1.x      <= req.box_x;
			box_s1.y      <= req.box_y;
			box_s1.width  <= req.box_width;
			box_s1.height <= req.box_height;
		end
		if (s1_move) begin
			cmd_s2   <= cmd_s1;
			box_s2   <= box_s1;
			area_s2  <= area_d;
			asp_h_s2 <= asp_h_d;
			asp_w_s2 <= asp_w_d;
		end
	end

	always_comb begin
		if (box_s2.width > box_s2.height) begin
			bad_aspect = !(bcf_pkg::ASP_PROD_W'(box_s2.width) < asp_h_s2);
		end else begin
			bad_aspect = !(asp_w_s2 > bcf_pkg::ASP_PROD_W'(box_s2.height));
		end
	end

	always_comb begin
		job.box    = box_s2;
		job.area   = area_s2;
		job.status = bcf_pkg::STAT_ACCEPTED;
		job.kind   = bcf_pkg::KIND_OFFER;
		unique case (cmd_s2)
			bcf_pkg::CMD_READ: begin
				job.kind = bcf_pkg::KIND_READ;
			end
			bcf_pkg::CMD_CLEAR: begin
				job.kind = bcf_pkg::KIND_CLEAR;
			end
			bcf_pkg::CMD_OFFER: begin
				if (area_s2 <= bcf_pkg::AREA_W'(min_area_q)) begin
					job.kind   = bcf_pkg::KIND_REJECT;
					job.status = bcf_pkg::STAT_SMALL;
				end else if (bad_aspect) begin
					job.kind   = bcf_pkg::KIND_REJECT;
					job.status = bcf_pkg::STAT_ASPECT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/bcf_queue.sv
// Short job queue between the front end and the table engine.
`default_nettype none

module bcf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bcf_pkg::job_t push_job,
	input  wire logic          push_valid,
	output logic               push_ready,
	output bcf_pkg::job_t      pop_job,
	output logic               pop_valid,
	input  wire logic          pop_ready
);

	bcf_pkg::job_t                  entry_q [bcf_pkg::QUEUE_DEPTH];
	logic [bcf_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [bcf_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [bcf_pkg::QUEUE_PTR_W:0]   fill_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (fill_q != (bcf_pkg::QUEUE_PTR_W + 1)'(bcf_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

>>> design/bcf_back.sv
// Table engine: holds the box table, scans for containment, compacts, reads out, drives results.
`default_nettype none

module bcf_back #(
	parameter int MAX_BOXES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bcf_pkg::job_t q_job,
	input  wire logic          q_valid,
	output logic               q_ready,
	bcf_res_if.source          res
);

	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_COMPACT  = 3'd3;
	localparam logic [2:0] ST_APPEND   = 3'd4;
	localparam logic [2:0] ST_EMIT     = 3'd5;
	localparam logic [2:0] ST_RD_ADDR  = 3'd6;
	localparam logic [2:0] ST_RD_EMIT  = 3'd7;

	bcf_pkg::box_t                box_mem [MAX_BOXES];
	logic                         mark_mem [MAX_BOXES];

	logic [2:0]                   state_q;
	bcf_pkg::job_t                job_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                n_q;
	logic [CW-1:0]                removed_q;
	logic [bcf_pkg::STATUS_W-1:0] pend_status_q;

	bcf_pkg::box_t                box_rd_s1;
	logic                         mark_rd_s1;
	logic                         rd_v_s1;
	logic [IW-1:0]                rd_idx_s1;

	logic                         v_s2;
	logic [IW-1:0]                idx_s2;
	logic [bcf_pkg::COORD_W-1:0]  w_s2;
	logic [bcf_pkg::COORD_W-1:0]  h_s2;
	logic [bcf_pkg::AREA_W-1:0]   other_s2;

	logic                         v_s3;
	logic [IW-1:0]                idx_s3;
	logic                         contained_s3;
	logic                         mark_s3;

	logic                         out_valid_q;
	logic [bcf_pkg::STATUS_W-1:0] out_status_q;
	logic [bcf_pkg::CNT_OUT_W-1:0] out_removed_q;
	logic [bcf_pkg::CNT_OUT_W-1:0] out_stored_q;
	bcf_pkg::box_t                out_entry_q;
	logic                         out_entry_valid_q;
	logic                         out_last_q;

	logic                         scan_issue;
	logic                         compact_issue;
	logic                         mem_re;
	logic [IW-1:0]                mem_ra;
	logic                         abort;
	logic                         mark_we;
	logic                         compact_we;
	logic                         box_we;
	bcf_pkg::box_t                box_wd;
	logic                         scan_done;
	logic                         compact_done;
	logic                         out_free;
	logic                         out_load;
	logic                         rd_last;

	logic [bcf_pkg::COORD_W:0]    a_end_x;
	logic [bcf_pkg::COORD_W:0]    a_end_y;
	logic [bcf_pkg::COORD_W:0]    b_end_x;
	logic [bcf_pkg::COORD_W:0]    b_end_y;
	logic [bcf_pkg::COORD_W-1:0]  lo_x;
	logic [bcf_pkg::COORD_W-1:0]  lo_y;
	logic [bcf_pkg::COORD_W:0]    hi_x;
	logic [bcf_pkg::COORD_W:0]    hi_y;
	logic [bcf_pkg::COORD_W-1:0]  w_d;
	logic [bcf_pkg::COORD_W-1:0]  h_d;
	logic [bcf_pkg::AREA_W-1:0]   other_d;
	logic [bcf_pkg::AREA_W-1:0]   inter_d;

	logic [bcf_pkg::STATUS_W-1:0] out_status_d;
	logic [bcf_pkg::CNT_OUT_W-1:0] out_removed_d;
	bcf_pkg::box_t                out_entry_d;
	logic                         out_entry_valid_d;
	logic                         out_last_d;

	assign q_ready       = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || res.ready;
	assign scan_issue    = (state_q == ST_SCAN) && (idx_q != count_q);
	assign compact_issue = (state_q == ST_COMPACT) && (idx_q != count_q);
	assign mem_re        = scan_issue || compact_issue || (state_q == ST_RD_ADDR);
	assign mem_ra        = idx_q[IW-1:0];
	assign abort         = (state_q == ST_SCAN) && v_s3 && contained_s3;
	assign mark_we       = (state_q == ST_SCAN) && v_s3 && !contained_s3;
	assign compact_we    = (state_q == ST_COMPACT) && rd_v_s1 && !mark_rd_s1;
	assign box_we        = compact_we || (state_q == ST_APPEND);
	assign box_wd        = (state_q == ST_APPEND) ? job_q.box : box_rd_s1;
	assign scan_done     = (state_q == ST_SCAN) && !scan_issue && !rd_v_s1 && !v_s2 && !v_s3;
	assign compact_done  = (state_q == ST_COMPACT) && !compact_issue && !rd_v_s1;
	assign rd_last       = ((idx_q + CW'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[n_q[IW-1:0]] <= box_wd;
		end
		if (mem_re) begin
			box_rd_s1 <= box_mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[idx_s3] <= mark_s3;
		end
		if (mem_re) begin
			mark_rd_s1 <= mark_mem[mem_ra];
		end
	end

	always_comb begin
		a_end_x = {1'b0, job_q.box.x} + {1'b0, job_q.box.width};
		a_end_y = {1'b0, job_q.box.y} + {1'b0, job_q.box.height};
		b_end_x = {1'b0, box_rd_s1.x} + {1'b0, box_rd_s1.width};
		b_end_y = {1'b0, box_rd_s1.y} + {1'b0, box_rd_s1.height};
		lo_x = (job_q.box.x > box_rd_s1.x) ? job_q.box.x : box_rd_s1.x;
		lo_y = (job_q.box.y > box_rd_s1.y) ? job_q.box.y : box_rd_s1.y;
		hi_x = (a_end_x < b_end_x) ? a_end_x : b_end_x;
		hi_y = (a_end_y < b_end_y) ? a_end_y : b_end_y;
		w_d = (hi_x > {1'b0, lo_x}) ? bcf_pkg::COORD_W'(hi_x - {1'b0, lo_x}) : '0;
		h_d = (hi_y > {1'b0, lo_y}) ? bcf_pkg::COORD_W'(hi_y - {1'b0, lo_y}) : '0;
		other_d = bcf_pkg::AREA_W'(box_rd_s1.width) * bcf_pkg::AREA_W'(box_rd_s1.height);
		inter_d = bcf_pkg::AREA_W'(w_s2) * bcf_pkg::AREA_W'(h_s2);
	end

	always_ff @(posedge clk) begin
		rd_idx_s1    <= idx_q[IW-1:0];
		idx_s2       <= rd_idx_s1;
		w_s2         <= w_d;
		h_s2         <= h_d;
		other_s2     <= other_d;
		idx_s3       <= idx_s2;
		contained_s3 <= (inter_d == job_q.area);
		mark_s3      <= (inter_d == other_s2);
		if (q_valid && q_ready) begin
			job_q <= q_job;
		end
	end

	always_comb begin
		out_load          = 1'b0;
		out_status_d      = pend_status_q;
		out_removed_d     = bcf_pkg::CNT_OUT_W'(removed_q);
		out_entry_d       = '0;
		out_entry_valid_d = 1'b0;
		out_last_d        = 1'b1;
		if ((state_q == ST_EMIT) && out_free) begin
			out_load = 1'b1;
		end else if ((state_q == ST_RD_EMIT) && out_free) begin
			out_load          = 1'b1;
			out_status_d      = bcf_pkg::STAT_ENTRY;
			out_removed_d     = '0;
			out_entry_d       = box_rd_s1;
			out_entry_valid_d = 1'b1;
			out_last_d        = rd_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q      <= out_status_d;
			out_removed_q     <= out_removed_d;
			out_stored_q      <= bcf_pkg::CNT_OUT_W'(count_q);
			out_entry_q       <= out_entry_d;
			out_entry_valid_q <= out_entry_valid_d;
			out_last_q        <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			n_q           <= '0;
			removed_q     <= '0;
			pend_status_q <= bcf_pkg::STAT_ACCEPTED;
			rd_v_s1       <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_v_s1 <= scan_issue || compact_issue;
			v_s2    <= (state_q == ST_SCAN) && rd_v_s1 && !abort;
			v_s3    <= (state_q == ST_SCAN) && v_s2 && !abort;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					removed_q <= '0;
					idx_q     <= '0;
					n_q       <= '0;
					unique case (job_q.kind)
						bcf_pkg::KIND_REJECT: begin
							pend_status_q <= job_q.status;
							state_q       <= ST_EMIT;
						end
						bcf_pkg::KIND_CLEAR: begin
							count_q       <= '0;
							pend_status_q <= bcf_pkg::STAT_CLEARED;
							state_q       <= ST_EMIT;
						end
						bcf_pkg::KIND_READ: begin
							if (count_q == '0) begin
								pend_status_q <= bcf_pkg::STAT_ENTRY;
								state_q       <= ST_EMIT;
							end else begin
								state_q <= ST_RD_ADDR;
							end
						end
						bcf_pkg::KIND_OFFER: begin
							state_q <= (count_q == '0) ? ST_APPEND : ST_SCAN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (abort) begin
						pend_status_q <= bcf_pkg::STAT_CONTAINED;
						removed_q     <= '0;
						state_q       <= ST_EMIT;
					end else begin
						if (mark_we && mark_s3) begin
							removed_q <= removed_q + CW'(1);
						end
						if (scan_done) begin
							if (removed_q == '0) begin
								if (count_q == CW'(MAX_BOXES)) begin
									pend_status_q <= bcf_pkg::STAT_FULL;
									state_q       <= ST_EMIT;
								end else begin
									n_q     <= count_q;
									state_q <= ST_APPEND;
								end
							end else begin
								idx_q   <= '0;
								n_q     <= '0;
								state_q <= ST_COMPACT;
							end
						end
					end
				end
				ST_COMPACT: begin
					if (compact_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (compact_we) begin
						n_q <= n_q + CW'(1);
					end
					if (compact_done) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					count_q       <= n_q + CW'(1);
					pend_status_q <= bcf_pkg::STAT_ACCEPTED;
					state_q       <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_EMIT;
				end
				ST_RD_EMIT: begin
					if (out_free) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= rd_last ? ST_IDLE : ST_RD_ADDR;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.removed_count = out_removed_q;
	assign res.stored_count  = out_stored_q;
	assign res.entry_x       = out_entry_q.x;
	assign res.entry_y       = out_entry_q.y;
	assign res.entry_width   = out_entry_q.width;
	assign res.entry_height  = out_entry_q.height;
	assign res.entry_valid   = out_entry_valid_q;
	assign res.last          = out_last_q;

endmodule

`default_nettype wire

>>> design/box_containment_filter_core.sv
// Top level of the box containment filter: front end, job queue and table engine.
//
//   Channel  Direction  Contents
//   req      in         command, box_x, box_y, box_width, box_height
//   res      out        status, removed_count, stored_count, entry_*, entry_valid, last
//   cfg      in         index (0 min_area, 1 max_aspect), data
//
// An offer against a non-empty table is scanned against the stored boxes in the table engine,
// and a compaction pass follows when stored boxes are removed, since the table memory
// has one read port. A readout returns one result per stored box, or a single result for
// an empty table. A result that waits on the output holds the engine.
// Reset clears the box count and the registers; the table memory itself is not cleared.
// The front end keeps accepting requests while the engine works or the result waits, until the job queue is full.

`default_nettype none

module box_containment_filter_core #(
	parameter int MAX_BOXES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bcf_req_if.sink   req,
	bcf_res_if.source res,
	bcf_cfg_if.sink   cfg
);

	bcf_pkg::job_t front_job;
	logic          front_valid;
	logic          front_ready;
	bcf_pkg::job_t queue_job;
	logic          queue_valid;
	logic          queue_ready;

	bcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	bcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (queue_job),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	bcf_back #(
		.MAX_BOXES (MAX_BOXES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (queue_job),
		.q_valid (queue_valid),
		.q_ready (queue_ready),
		.res     (res)
	);

endmodule

`default_nettype wire
